### src/fwlru_pkg.sv
// Shared constants and types for the four-way LRU cache tag store.
`default_nettype none

package fwlru_pkg;

    // Cache geometry.
    localparam int NUM_SETS    = 8;
    localparam int NUM_WAYS    = 4;
    localparam int OFFSET_BITS = 3;
    localparam int ADDR_BITS   = 32;

    // Derived widths.
    localparam int SET_BITS     = $clog2(NUM_SETS);
    localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_BITS     = ($clog2(NUM_WAYS) > 0) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_BITS     = WAY_BITS;
    localparam int REF_BITS     = AGE_BITS + 1;
    localparam int BLOCK_BITS   = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_BITS     = BLOCK_BITS - SET_BITS;

    // Stream payload widths.
    localparam int IN_DATA_BITS  = 32;
    localparam int VICTIM_BITS   = 26;
    localparam int OUT_FLD_BITS  = 2 + VICTIM_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FLD_BITS + 7) / 8) * 8;

    // Contents of one set.
    typedef struct packed {
        logic [NUM_WAYS-1:0]               valid;
        logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag;
        logic [NUM_WAYS-1:0][AGE_BITS-1:0] age;
    } t_set_row;

    // Outcome of one lookup, including the updated set.
    typedef struct packed {
        logic                   hit;
        logic                   evicted;
        logic [VICTIM_BITS-1:0] victim_tag;
        t_set_row               row;
    } t_lookup;

endpackage

`default_nettype wire

### src/four_way_lru_cache_tags_core.sv
// Top level of the four-way set-associative cache tag store with true LRU.
`default_nettype none

// Each transfer on the slave stream carries one byte address; the block drops
// the offset bits, splits the block number into a set index and a tag, looks
// the tag up in the four ways of its set and returns one result transfer on
// the master stream with hit, evicted and the evicted line's tag (zero when
// nothing was evicted). A hit makes the line most recently used, a miss fills
// the lowest free way, and a miss into a full set replaces the least recently
// used line. All valid bits and ages are cleared by reset, so the block is
// usable in the first cycle after reset with no clearing pass. The block takes
// one address per cycle unless the master side stalls it: the address is
// captured in an input register, then the tag compare, victim choice and
// age update of the flop-based set storage run combinationally and land in
// the result register while the set is written back. That single
// read-modify-write of one set per cycle sets the rate, and since the next
// lookup always sees the storage already updated, back-to-back accesses to
// the same set need no forwarding. Backpressure on the master side stalls
// both registers; the slave side keeps accepting while the input register
// is empty or moving on.
module four_way_lru_cache_tags_core (
    input  wire  logic                                   i_clk,
    input  wire  logic                                   i_rst_n,
    // Slave stream. tdata: [31:0] byte_address.
    input  wire  logic                                   i_s_tvalid,
    output logic                                         o_s_tready,
    input  wire  logic [fwlru_pkg::IN_DATA_BITS-1:0]     i_s_tdata,
    // Master stream. tdata: [0] hit, [1] evicted, [27:2] victim_tag,
    // [31:28] zero.
    output logic                                         o_m_tvalid,
    input  wire  logic                                   i_m_tready,
    output logic [fwlru_pkg::OUT_DATA_BITS-1:0]          o_m_tdata
);

    // Input register.
    logic                                  r_in_valid;
    logic [fwlru_pkg::ADDR_BITS-1:0]       r_addr;

    // Result register.
    logic                                  r_out_valid;
    logic                                  r_hit;
    logic                                  r_evicted;
    logic [fwlru_pkg::VICTIM_BITS-1:0]     r_victim;

    // Set storage in flops, one row per set.
    logic [fwlru_pkg::NUM_SETS-1:0][fwlru_pkg::NUM_WAYS-1:0]  r_valid;
    logic [fwlru_pkg::NUM_SETS-1:0][fwlru_pkg::NUM_WAYS-1:0]
          [fwlru_pkg::AGE_BITS-1:0]                           r_age;
    logic [fwlru_pkg::NUM_SETS-1:0][fwlru_pkg::NUM_WAYS-1:0]
          [fwlru_pkg::TAG_BITS-1:0]                           r_tag;

    logic                                  w_advance;
    logic                                  w_do_lookup;
    logic [fwlru_pkg::BLOCK_BITS-1:0]      w_block;
    logic [fwlru_pkg::SET_IDX_BITS-1:0]    w_set;
    logic [fwlru_pkg::TAG_BITS-1:0]        w_tag;
    fwlru_pkg::t_set_row                   w_row;
    fwlru_pkg::t_lookup                    n_res;

    // The result register can load when it is empty or being drained.
    assign w_advance   = !r_out_valid || i_m_tready;
    assign w_do_lookup = r_in_valid && w_advance;
    assign o_s_tready  = !r_in_valid || w_advance;

    // The offset bits are dropped; the set count is a power of two, so the
    // split into set index and tag is a plain bit split.
    assign w_block = r_addr[fwlru_pkg::ADDR_BITS-1:fwlru_pkg::OFFSET_BITS];
    assign w_set   = fwlru_pkg::SET_IDX_BITS'(w_block % fwlru_pkg::NUM_SETS);
    assign w_tag   = fwlru_pkg::TAG_BITS'(w_block / fwlru_pkg::NUM_SETS);

    // The row is packed valid, tag, age from the top down.
    assign w_row = {r_valid[w_set], r_tag[w_set], r_age[w_set]};

    fwlru_set_lookup u_set_lookup (
        .i_row (w_row),
        .i_tag (w_tag),
        .o_res (n_res)
    );

    // Control state and the reset-cleared part of the set storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_age       <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_do_lookup) begin
                r_valid[w_set] <= n_res.row.valid;
                r_age[w_set]   <= n_res.row.age;
            end
        end
    end

    // Payload registers and tags; tags are read only behind a valid bit.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_addr <= i_s_tdata[fwlru_pkg::ADDR_BITS-1:0];
        end
        if (w_do_lookup) begin
            r_tag[w_set] <= n_res.row.tag;
            r_hit        <= n_res.hit;
            r_evicted    <= n_res.evicted;
            r_victim     <= n_res.victim_tag;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = fwlru_pkg::OUT_DATA_BITS'({r_victim, r_evicted, r_hit});

endmodule

`default_nettype wire

### src/fwlru_set_lookup.sv
// Tag compare, way selection and LRU age update for one cache set.
`default_nettype none

module fwlru_set_lookup (
    input  wire  fwlru_pkg::t_set_row                 i_row,
    input  wire  logic [fwlru_pkg::TAG_BITS-1:0]      i_tag,
    output fwlru_pkg::t_lookup                        o_res
);

    logic                               hit;
    logic [fwlru_pkg::WAY_BITS-1:0]     hit_way;
    logic                               has_free;
    logic [fwlru_pkg::WAY_BITS-1:0]     free_way;
    logic [fwlru_pkg::WAY_BITS-1:0]     lru_way;
    logic [fwlru_pkg::WAY_BITS-1:0]     sel_way;
    logic [fwlru_pkg::REF_BITS-1:0]     ref_age;
    logic                               evict;

    always_comb begin
        // Lowest matching way and lowest free way.
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int i = fwlru_pkg::NUM_WAYS - 1; i >= 0; i--) begin
            if (i_row.valid[i] && (i_row.tag[i] == i_tag)) begin
                hit     = 1'b1;
                hit_way = fwlru_pkg::WAY_BITS'(i);
            end
            if (!i_row.valid[i]) begin
                has_free = 1'b1;
                free_way = fwlru_pkg::WAY_BITS'(i);
            end
        end

        // Oldest way; the lowest-numbered one wins a tie.
        lru_way = '0;
        for (int i = 1; i < fwlru_pkg::NUM_WAYS; i++) begin
            if (i_row.age[i] > i_row.age[lru_way]) begin
                lru_way = fwlru_pkg::WAY_BITS'(i);
            end
        end

        evict = 1'b0;
        priority if (hit) begin
            sel_way = hit_way;
            ref_age = {1'b0, i_row.age[hit_way]};
        end else if (has_free) begin
            sel_way = free_way;
            ref_age = fwlru_pkg::REF_BITS'(fwlru_pkg::NUM_WAYS);
        end else begin
            sel_way = lru_way;
            ref_age = {1'b0, i_row.age[lru_way]};
            evict   = 1'b1;
        end

        o_res.hit        = hit;
        o_res.evicted    = evict;
        o_res.victim_tag = evict ? fwlru_pkg::VICTIM_BITS'(i_row.tag[lru_way]) : '0;
        o_res.row        = i_row;

        // Ways younger than the touched line age by one; the touched line
        // becomes the most recently used.
        for (int i = 0; i < fwlru_pkg::NUM_WAYS; i++) begin
            if (fwlru_pkg::WAY_BITS'(i) == sel_way) begin
                o_res.row.age[i]   = '0;
                o_res.row.valid[i] = 1'b1;
                o_res.row.tag[i]   = i_tag;
            end else if (i_row.valid[i] && ({1'b0, i_row.age[i]} < ref_age)) begin
                o_res.row.age[i] = i_row.age[i] + fwlru_pkg::AGE_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the four-way LRU cache tag store with random and directed lookups.

module testbench;

    localparam int NUM_SETS      = fwlru_pkg::NUM_SETS;
    localparam int NUM_WAYS      = fwlru_pkg::NUM_WAYS;
    localparam int OFFSET_BITS   = fwlru_pkg::OFFSET_BITS;
    localparam int ADDR_BITS     = fwlru_pkg::ADDR_BITS;
    localparam int SET_BITS      = fwlru_pkg::SET_BITS;
    localparam int TAG_BITS      = fwlru_pkg::TAG_BITS;
    localparam int IN_DATA_BITS  = fwlru_pkg::IN_DATA_BITS;
    localparam int VICTIM_BITS   = fwlru_pkg::VICTIM_BITS;
    localparam int OUT_FLD_BITS  = fwlru_pkg::OUT_FLD_BITS;
    localparam int OUT_DATA_BITS = fwlru_pkg::OUT_DATA_BITS;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 4;
    localparam int PIPE_LATENCY    = 2;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int WATCHDOG_CYCLES = 200000;
    localparam int HOT_TAGS        = 6;
    localparam int WARM_TAGS       = 12;
    localparam int PAD_BITS        = OUT_DATA_BITS - OUT_FLD_BITS;

    // Fields of one lookup result as they travel on the master stream.
    typedef struct packed {
        logic                   hit;
        logic                   evicted;
        logic [VICTIM_BITS-1:0] victim_tag;
    } t_lookup_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata;     // [31:0] byte_address
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;     // [0] hit, [1] evicted, [27:2] victim_tag, [31:28] zero

    four_way_lru_cache_tags_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Shadow copy of the tag store, updated once per accepted address.
    bit                  tag_valid [NUM_SETS][NUM_WAYS];
    logic [TAG_BITS-1:0] tag_store [NUM_SETS][NUM_WAYS];
    int                  lru_age   [NUM_SETS][NUM_WAYS];

    // Lookups whose result transfer has not arrived yet, oldest first.
    t_lookup_result expected_lookups[$];

    logic [TAG_BITS-1:0] hot_tags  [HOT_TAGS];
    logic [TAG_BITS-1:0] warm_tags [WARM_TAGS];

    int unsigned error_count;
    bit          sender_bursts_on;
    bit          receiver_bursts_on;
    // A long receiver hold is requested by bumping the sequence number.
    int unsigned stall_hold_len;
    int unsigned stall_hold_seq;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

    // Looks one address up in the shadow store, applies the true LRU update and
    // returns the result the block should produce.
    function automatic t_lookup_result predict_lookup(input logic [IN_DATA_BITS-1:0] addr);
        longint unsigned     blk;
        int                  set_idx;
        int                  way;
        int                  pivot_age;
        logic [TAG_BITS-1:0] tag;
        t_lookup_result      res;
        blk     = 64'(addr[ADDR_BITS-1:0]) >> OFFSET_BITS;
        set_idx = int'(blk % NUM_SETS);
        tag     = TAG_BITS'(blk / NUM_SETS);
        res     = '0;
        way     = -1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way < 0 && tag_valid[set_idx][w] && tag_store[set_idx][w] == tag)
                way = w;
        end
        if (way >= 0) begin
            res.hit   = 1'b1;
            pivot_age = lru_age[set_idx][way];
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (way < 0 && !tag_valid[set_idx][w])
                    way = w;
            end
            if (way >= 0) begin
                // A free way is filled; every valid line ages by one.
                pivot_age = NUM_WAYS;
            end else begin
                // Full set: the oldest line goes, lowest way on a tie.
                way = 0;
                for (int w = 1; w < NUM_WAYS; w++) begin
                    if (lru_age[set_idx][w] > lru_age[set_idx][way])
                        way = w;
                end
                res.evicted    = 1'b1;
                res.victim_tag = VICTIM_BITS'(tag_store[set_idx][way]);
                pivot_age      = lru_age[set_idx][way];
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w != way && tag_valid[set_idx][w] && lru_age[set_idx][w] < pivot_age)
                lru_age[set_idx][w]++;
        end
        lru_age[set_idx][way]   = 0;
        tag_valid[set_idx][way] = 1'b1;
        tag_store[set_idx][way] = tag;
        return res;
    endfunction

    function automatic logic [IN_DATA_BITS-1:0] make_address(input logic [TAG_BITS-1:0] tag,
                                                             input int set_idx,
                                                             input int offset);
        return (IN_DATA_BITS'(tag) << (SET_BITS + OFFSET_BITS))
             | (IN_DATA_BITS'(set_idx % NUM_SETS) << OFFSET_BITS)
             | IN_DATA_BITS'(offset % (1 << OFFSET_BITS));
    endfunction

    // Mostly addresses from small tag pools so that sets fill, hit and evict;
    // the rest are fully random addresses that toggle every bit.
    function automatic logic [IN_DATA_BITS-1:0] pick_random_address();
        int unsigned choice;
        int          set_idx;
        int          offset;
        choice  = $urandom_range(0, 99);
        set_idx = $urandom_range(0, NUM_SETS - 1);
        offset  = $urandom_range(0, (1 << OFFSET_BITS) - 1);
        if (choice < 60)
            return make_address(hot_tags[$urandom_range(0, HOT_TAGS - 1)], set_idx, offset);
        else if (choice < 85)
            return make_address(warm_tags[$urandom_range(0, WARM_TAGS - 1)], set_idx, offset);
        else
            return IN_DATA_BITS'($urandom);
    endfunction

    task automatic refresh_tag_pools();
        for (int i = 0; i < HOT_TAGS; i++)
            hot_tags[i] = ($urandom_range(0, 1) == 0) ? TAG_BITS'($urandom_range(0, 15))
                                                      : TAG_BITS'($urandom);
        for (int i = 0; i < WARM_TAGS; i++)
            warm_tags[i] = TAG_BITS'($urandom);
    endtask

    // Offers one address on the slave stream, optionally after an idle burst,
    // and records the expected result once the transfer is taken.
    task automatic send_address(input logic [IN_DATA_BITS-1:0] addr);
        int unsigned gap;
        gap = 0;
        if (sender_bursts_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= IN_DATA_BITS'($urandom);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        do @(posedge i_clk); while (!o_s_tready);
        expected_lookups.insert(expected_lookups.size(), predict_lookup(addr));
    endtask

    // Receiver side: random ready bursts plus the long hold used for backpressure.
    initial begin : ready_driver
        int unsigned seen_seq;
        int unsigned hold_left;
        int unsigned burst_left;
        logic        ready_next;
        seen_seq   = 0;
        hold_left  = 0;
        burst_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold_seq != seen_seq) begin
                seen_seq  = stall_hold_seq;
                hold_left = stall_hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                ready_next = 1'b0;
            end else if (receiver_bursts_on && $urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(1, 6) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_m_tready <= ready_next;
        end
    end

    // Every result transfer is matched against the oldest pending lookup.
    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_lookups.size() == 0) begin
                $error("unexpected result transfer: tdata %h", o_m_tdata);
                error_count++;
            end else begin
                want = expected_lookups[0];
                expected_lookups.delete(0);
                if (o_m_tdata[0] !== want.hit) begin
                    $error("hit mismatch: expected %0d, got %0d", want.hit, o_m_tdata[0]);
                    error_count++;
                end
                if (o_m_tdata[1] !== want.evicted) begin
                    $error("evicted mismatch: expected %0d, got %0d",
                           want.evicted, o_m_tdata[1]);
                    error_count++;
                end
                if (o_m_tdata[VICTIM_BITS+1:2] !== want.victim_tag) begin
                    $error("victim_tag mismatch: expected %h, got %h",
                           want.victim_tag, o_m_tdata[VICTIM_BITS+1:2]);
                    error_count++;
                end
                if (o_m_tdata[OUT_DATA_BITS-1:OUT_FLD_BITS] !== '0) begin
                    $error("padding mismatch: expected %h, got %h", {PAD_BITS{1'b0}},
                           o_m_tdata[OUT_DATA_BITS-1:OUT_FLD_BITS]);
                    error_count++;
                end
            end
        end
    end

    task automatic apply_reset();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                tag_valid[s][w] = 1'b0;
                tag_store[s][w] = '0;
                lru_age[s][w]   = 0;
            end
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Lowest and highest addresses, and offset bits that must not matter.
    task automatic test_address_extremes();
        send_address(32'h0000_0000);
        send_address(32'h0000_0007);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFF8);
        send_address(make_address('0, NUM_SETS - 1, 0));
    endtask

    // Fills one set through its free ways, then walks LRU order with hits and
    // misses so that each miss into the full set evicts the oldest line.
    task automatic test_lru_replacement();
        for (int t = 1; t <= NUM_WAYS; t++)
            send_address(make_address(TAG_BITS'(t), 1, t));
        send_address(make_address(TAG_BITS'(1), 1, 0));
        send_address(make_address(TAG_BITS'(5), 1, 0));
        send_address(make_address(TAG_BITS'(3), 1, 0));
        send_address(make_address(TAG_BITS'(6), 1, 0));
        send_address(make_address(TAG_BITS'(7), 1, 0));
    endtask

    // The all-ones tag in the top set ends up as the oldest line and is evicted.
    task automatic test_widest_victim_tag();
        send_address(make_address(TAG_BITS'(26'h155_5555), NUM_SETS - 1, 1));
        send_address(make_address(TAG_BITS'(26'h2AA_AAAA), NUM_SETS - 1, 2));
        send_address(make_address('0, NUM_SETS - 1, 3));
        send_address(make_address(TAG_BITS'(5), NUM_SETS - 1, 4));
    endtask

    // Random traffic in chunks, with idling switched on and off between chunks.
    task automatic test_random_traffic(input int chunks, input int per_chunk);
        for (int c = 0; c < chunks; c++) begin
            refresh_tag_pools();
            sender_bursts_on   = (c % 3) != 2;
            receiver_bursts_on = (c % 4) != 3;
            repeat (per_chunk) send_address(pick_random_address());
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and the
    // slave side to stall while addresses keep being offered.
    task automatic test_input_backpressure();
        sender_bursts_on   = 1'b0;
        receiver_bursts_on = 1'b0;
        stall_hold_len     = 60;
        stall_hold_seq++;
        repeat (40) send_address(pick_random_address());
    endtask

    task automatic test_back_to_back(input int count);
        sender_bursts_on   = 1'b0;
        receiver_bursts_on = 1'b0;
        refresh_tag_pools();
        repeat (count) send_address(pick_random_address());
    endtask

    task automatic drain_results();
        int drain_cycles;
        drain_cycles = 0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (expected_lookups.size() != 0) begin
            $error("%0d result transfers never arrived", expected_lookups.size());
            error_count++;
        end
        // Wait on so that any stray result transfer is caught.
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin : run
        error_count        = 0;
        sender_bursts_on   = 1'b0;
        receiver_bursts_on = 1'b0;
        stall_hold_len     = 0;
        stall_hold_seq     = 0;
        apply_reset();
        test_address_extremes();
        test_lru_replacement();
        test_widest_victim_tag();
        test_random_traffic(12, 100);
        test_input_backpressure();
        test_back_to_back(440);
        drain_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### four_way_lru_cache_tags_core.f
src/fwlru_pkg.sv
src/fwlru_set_lookup.sv
src/four_way_lru_cache_tags_core.sv
tb/sv/testbench.sv
